@@ hdl/scm_pkg.sv @@
`timescale 1ns / 1ps

package scm_pkg;

   // Width of the raw converter count field and of the Q16 gain.
   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int LEVEL_W  = 8;
   localparam int CHAN_W   = 2;
   localparam int CSR_W    = 16;

   // Temperature gain is 100 * 3.3 / 4095 in unsigned Q16, rounded.
   localparam logic [GAIN_W-1:0]  TEMP_GAIN   = 16'd5281;
   localparam logic [12:0]        TEMP_OFFSET = 13'd50;
   localparam logic [PROD_W:0]    Q16_HALF    = 29'd32768;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

   localparam logic [LEVEL_W-1:0] WARN_THRESHOLD_RST = 8'd80;
   localparam logic [GAIN_W-1:0]  VOLT_SCALE_RST     = 16'd687;

   typedef enum logic [0:0] {
      CSR_WARN_THRESHOLD = 1'b0,
      CSR_VOLT_SCALE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [LEVEL_W-1:0] level;
      logic               report;
      logic               warning;
   } rsp_type;

   // One memory word per channel.
   typedef struct packed {
      logic [LEVEL_W-1:0] filtered;
      logic [LEVEL_W-1:0] last_reported;
   } chan_state_type;

endpackage

@@ hdl/sensor_channel_monitor.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Contents
// req       in         req_valid, req_ready, req_data   channel number, raw count
// rsp       out        rsp_valid, rsp_ready, rsp_data   channel, level, report, warning
// csr       in         csr_we, csr_index, csr_wdata     warn_threshold, volt_scale
//
// One item per clock cycle sustained while the output does not stall; an item
// accepted passes through stage one, which multiplies and reads the channel memory,
// stage two, which filters and writes back, and the output register with the result.
// Synchronous reset clears the pipeline valids and the per-channel seen bits.
// A stalled output stops only the stages behind it that are full.
module sensor_channel_monitor #(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  scm_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output scm_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  scm_pkg::csr_index_type      csr_index,
   input  logic [scm_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(CHANNELS);
   localparam logic [scm_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= scm_pkg::SAMPLE_W) ? '1 :
      scm_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   // Configuration registers.
   logic [scm_pkg::LEVEL_W-1:0] warn_threshold_ff;
   logic [scm_pkg::GAIN_W-1:0]  volt_scale_ff;

   // Pipeline registers.
   logic                           s1_valid_ff;
   logic [scm_pkg::CHAN_W-1:0]     s1_chan_ff;
   logic [scm_pkg::SAMPLE_W-1:0]   s1_count_ff;
   logic                           s2_valid_ff;
   logic [scm_pkg::CHAN_W-1:0]     s2_chan_ff;
   logic [scm_pkg::PROD_W-1:0]     s2_prod_ff;
   scm_pkg::chan_state_type        rd_ff;
   logic                           fwd_ff;
   scm_pkg::chan_state_type        fwd_data_ff;
   logic                           rsp_valid_ff;
   scm_pkg::rsp_type               rsp_data_ff;
   logic [CHANNELS-1:0]            seen_ff;

   scm_pkg::chan_state_type        state_mem [CHANNELS];

   logic                           en1;
   logic                           en2;
   logic [AW-1:0]                  s1_addr;
   logic [AW-1:0]                  s2_addr;
   logic                           s1_in_range;
   logic                           s2_in_range;
   logic [scm_pkg::GAIN_W-1:0]     gain;
   logic [scm_pkg::PROD_W-1:0]     prod_in;
   logic [scm_pkg::PROD_W:0]       rounded;
   logic [12:0]                    q;
   logic [12:0]                    q_temp;
   logic                           is_temp;
   logic [scm_pkg::LEVEL_W-1:0]    conv;
   scm_pkg::chan_state_type        old_state;
   logic                           seen_now;
   logic signed [scm_pkg::LEVEL_W:0] diff;
   logic signed [scm_pkg::LEVEL_W:0] half;
   logic signed [scm_pkg::LEVEL_W:0] smoothed;
   logic [scm_pkg::LEVEL_W-1:0]    y;
   logic [scm_pkg::LEVEL_W-1:0]    last;
   logic                           wr_en;
   scm_pkg::chan_state_type        wr_data;
   scm_pkg::rsp_type               rsp_data_in;

   assign en2       = !rsp_valid_ff || rsp_ready;
   assign en1       = !s2_valid_ff || en2;
   assign req_ready = !s1_valid_ff || en1;

   assign s1_addr     = AW'(s1_chan_ff);
   assign s2_addr     = AW'(s2_chan_ff);
   assign s1_in_range = (32'(s1_chan_ff) < CHANNELS);
   assign s2_in_range = (32'(s2_chan_ff) < CHANNELS);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_threshold_ff <= scm_pkg::WARN_THRESHOLD_RST;
         volt_scale_ff     <= scm_pkg::VOLT_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            scm_pkg::CSR_WARN_THRESHOLD:
               warn_threshold_ff <= csr_wdata[scm_pkg::LEVEL_W-1:0];
            scm_pkg::CSR_VOLT_SCALE:
               volt_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage one: capture the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_chan_ff  <= req_data.channel;
         s1_count_ff <= req_data.sample & SAMPLE_MASK;
      end
   end

   // Stage one multiply: temperature channels use the fixed gain.
   assign gain    = s1_chan_ff[1] ? volt_scale_ff : scm_pkg::TEMP_GAIN;
   assign prod_in = scm_pkg::PROD_W'(s1_count_ff) * scm_pkg::PROD_W'(gain);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en1) begin
         s2_valid_ff <= s1_valid_ff;
         // The memory read below sees the old word when stage two writes the
         // same channel in this cycle, so the written word is carried along.
         fwd_ff      <= wr_en && (s2_addr == s1_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s2_chan_ff  <= s1_chan_ff;
         s2_prod_ff  <= prod_in;
         fwd_data_ff <= wr_data;
      end
   end

   // Channel state memory: read in stage one, written back in stage two.
   always_ff @(posedge clock) begin
      if (en1 && s1_in_range) begin
         rd_ff <= state_mem[s1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[s2_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (wr_en) begin
         seen_ff[s2_addr] <= 1'b1;
      end
   end

   // Stage two: round, offset, clip, filter and compare.
   always_comb begin
      is_temp = !s2_chan_ff[1];
      rounded = {1'b0, s2_prod_ff} + scm_pkg::Q16_HALF;
      q       = rounded[scm_pkg::PROD_W-:13];
      q_temp  = (q < scm_pkg::TEMP_OFFSET) ? '0 : (q - scm_pkg::TEMP_OFFSET);
      if (is_temp) begin
         conv = (q_temp > 13'(scm_pkg::LEVEL_MAX)) ? scm_pkg::LEVEL_MAX
                                                    : q_temp[scm_pkg::LEVEL_W-1:0];
      end else begin
         conv = (q > 13'(scm_pkg::LEVEL_MAX)) ? scm_pkg::LEVEL_MAX
                                               : q[scm_pkg::LEVEL_W-1:0];
      end

      old_state = fwd_ff ? fwd_data_ff : rd_ff;
      seen_now  = seen_ff[s2_addr];

      // y - floor((y - x) / 2) with an arithmetic shift of the difference.
      diff     = $signed({1'b0, old_state.filtered}) - $signed({1'b0, conv});
      half     = diff >>> 1;
      smoothed = $signed({1'b0, old_state.filtered}) - half;
      y        = seen_now ? smoothed[scm_pkg::LEVEL_W-1:0] : conv;
      last     = seen_now ? old_state.last_reported : '0;

      // After an update the last reported value always equals the new level.
      wr_data.filtered      = y;
      wr_data.last_reported = y;
      wr_en = s2_valid_ff && en2 && s2_in_range;

      rsp_data_in.out_channel = s2_chan_ff;
      if (s2_in_range) begin
         rsp_data_in.level   = y;
         rsp_data_in.report  = (y != last);
         rsp_data_in.warning = is_temp && (y > warn_threshold_ff);
      end else begin
         rsp_data_in.level   = '0;
         rsp_data_in.report  = 1'b0;
         rsp_data_in.warning = 1'b0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en2) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Voltage channels never raise the warning flag.
   a_warn_temp_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.warning && rsp_data_ff.out_channel[1]))
      else $error("warning flag set on a voltage channel");

   // A write-back marks its channel as seen.
   a_seen_after_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> seen_ff[$past(s2_addr)])
      else $error("channel not marked seen after write-back");

   // A new result only comes out of a full stage two.
   a_rsp_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without an item in stage two");

   // An item held in stage one keeps its contents.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !en1) |=> (s1_valid_ff && $stable(s1_chan_ff)
                                 && $stable(s1_count_ff)))
      else $error("stage one item lost while stalled");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam logic [7:0]  LIMIT_AT_RESET = 8'd80;
   localparam logic [15:0] GAIN_AT_RESET  = 16'd687;
   localparam int          DEG_GAIN_Q16   = 5281;
   localparam int          DEG_OFFSET     = 50;
   localparam int          ROUND_HALF     = 32768;
   localparam int          PHASE_ITEMS    = 235;

   // Tracks per-channel filter state and queues the result each item should produce.
   class level_tracker;
      logic [7:0]       warn_limit;
      logic [15:0]      volt_gain;
      logic [7:0]       filtered_level [4];
      logic [7:0]       reported_level [4];
      bit               has_sample [4];
      scm_pkg::rsp_type expected_rsps [$];
      int               errors;
      int               checked;
      int               reports;
      int               warnings;

      function new();
         warn_limit = LIMIT_AT_RESET;
         volt_gain  = GAIN_AT_RESET;
         for (int i = 0; i < 4; i++) begin
            filtered_level[i] = '0;
            reported_level[i] = '0;
            has_sample[i]     = 1'b0;
         end
         errors   = 0;
         checked  = 0;
         reports  = 0;
         warnings = 0;
      endfunction

      function void write_reg(scm_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            scm_pkg::CSR_WARN_THRESHOLD: warn_limit = value[7:0];
            scm_pkg::CSR_VOLT_SCALE:     volt_gain  = value;
            default: ;
         endcase
      endfunction

      function logic [7:0] convert_count(logic [1:0] ch, logic [11:0] count);
         longint unsigned q;
         q = 64'(count);
         if (ch < 2) begin
            q = (q * DEG_GAIN_Q16 + ROUND_HALF) >> 16;
            if (q < DEG_OFFSET)
               return 8'd0;
            q = q - DEG_OFFSET;
         end else begin
            q = (q * 64'(volt_gain) + ROUND_HALF) >> 16;
         end
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      // Halves the gap to the new value; an odd gap rounds toward the larger of the two values.
      function logic [7:0] smooth_level(logic [7:0] y, logic [7:0] x);
         int unsigned yi;
         int unsigned xi;
         yi = 32'(y);
         xi = 32'(x);
         if (yi >= xi)
            return 8'(yi - ((yi - xi) >> 1));
         return 8'(yi + ((xi - yi + 1) >> 1));
      endfunction

      function void note_sample(scm_pkg::req_type item);
         scm_pkg::rsp_type exp_rsp;
         logic [7:0]       x;
         int               ch;
         ch = int'(item.channel);
         x  = convert_count(item.channel, item.sample);
         if (!has_sample[ch]) begin
            filtered_level[ch] = x;
            has_sample[ch]     = 1'b1;
         end else begin
            filtered_level[ch] = smooth_level(filtered_level[ch], x);
         end
         exp_rsp.out_channel = item.channel;
         exp_rsp.level       = filtered_level[ch];
         exp_rsp.report      = (filtered_level[ch] != reported_level[ch]);
         exp_rsp.warning     = (ch < 2) && (filtered_level[ch] > warn_limit);
         if (exp_rsp.report)
            reported_level[ch] = filtered_level[ch];
         expected_rsps.push_back(exp_rsp);
      endfunction

      function void check_result(scm_pkg::rsp_type got);
         scm_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: channel %0d level %0d", got.out_channel, got.level);
            errors++;
            return;
         end
         want = expected_rsps.pop_front();
         checked++;
         if (got.report)
            reports++;
         if (got.warning)
            warnings++;
         if (got.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
            errors++;
         end
         if (got.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            errors++;
         end
         if (got.report !== want.report) begin
            $error("report: expected %0b, got %0b", want.report, got.report);
            errors++;
         end
         if (got.warning !== want.warning) begin
            $error("warning: expected %0b, got %0b", want.warning, got.warning);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   scm_pkg::req_type       req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   scm_pkg::rsp_type       rsp_data;
   logic                   csr_we;
   scm_pkg::csr_index_type csr_index;
   logic [15:0]            csr_wdata;

   level_tracker tracker;
   int           sender_idle_max;
   int           receiver_idle_max;
   int           items_sent;
   int           settings_used;

   sensor_channel_monitor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** sensor_channel_monitor: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_data);
         if (req_valid && req_ready)
            tracker.note_sample(req_data);
      end
   end

   task automatic send_sample(input logic [1:0] ch, input logic [11:0] count);
      scm_pkg::req_type item;
      int               gap;
      item.channel = ch;
      item.sample  = count;
      gap = (sender_idle_max == 0) ? 0 : $urandom_range(0, sender_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic accept_results();
      int stall;
      forever begin
         stall = (receiver_idle_max == 0) ? 0 : $urandom_range(0, receiver_idle_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic apply_settings(input logic [7:0] limit, input logic [15:0] gain);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      csr_we    <= 1'b1;
      csr_index <= scm_pkg::CSR_WARN_THRESHOLD;
      csr_wdata <= {junk, limit};
      @(posedge clock);
      tracker.write_reg(scm_pkg::CSR_WARN_THRESHOLD, {junk, limit});
      csr_index <= scm_pkg::CSR_VOLT_SCALE;
      csr_wdata <= gain;
      @(posedge clock);
      tracker.write_reg(scm_pkg::CSR_VOLT_SCALE, gain);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Mostly runs of related samples on one channel so the filter settles and report
   // goes quiet, with single random items and an occasional wait for a drain mixed in.
   task automatic run_phase(input int count);
      int         done;
      int         pick;
      int         run_len;
      int         base;
      int         s;
      int         near;
      logic [1:0] ch;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            hold_until_drained();
         end else if (pick < 26) begin
            ch      = 2'($urandom_range(0, 3));
            run_len = $urandom_range(3, 12);
            near = ((int'(tracker.warn_limit) + DEG_OFFSET) * 65536) / DEG_GAIN_Q16;
            if (near > 4095)
               near = 4095;
            case ($urandom_range(0, 3))
               0: base = near;
               1: base = ($urandom_range(0, 1) != 0) ? 4095 : 0;
               default: base = $urandom_range(0, 4095);
            endcase
            for (int k = 0; k < run_len; k++) begin
               s = base;
               if (k % 3 != 0)
                  s = base + int'($urandom_range(0, 80)) - 40;
               if (s < 0)
                  s = 0;
               if (s > 4095)
                  s = 4095;
               send_sample(ch, 12'(s));
               done++;
            end
         end else begin
            send_sample(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
            done++;
         end
      end
   endtask

   initial begin
      logic [7:0]  limit;
      logic [15:0] gain;
      tracker           = new();
      items_sent        = 0;
      settings_used     = 0;
      sender_idle_max   = 6;
      receiver_idle_max = 6;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= scm_pkg::CSR_WARN_THRESHOLD;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         accept_results();
      join_none

      // A first temperature sample that converts to zero must not raise report.
      send_sample(2'd0, 12'd0);
      send_sample(2'd2, 12'd0);
      send_sample(2'd1, 12'd4095);
      send_sample(2'd3, 12'd4095);
      send_sample(2'd0, 12'd4095);
      send_sample(2'd1, 12'd0);
      send_sample(2'd2, 12'd0);
      send_sample(2'd2, 12'd4095);
      send_sample(2'd3, 12'd0);
      // Repeated counts near the reset threshold let the filter settle on it.
      repeat (8) send_sample(2'd0, 12'd1613);
      repeat (4) send_sample(2'd1, 12'd1626);
      send_sample(2'd3, 12'd2048);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin limit = 8'd0;   gain = 16'hFFFF; end
            1: begin limit = 8'd255; gain = 16'd0;    end
            2: begin limit = 8'd80;  gain = 16'd687;  end
            3: begin limit = 8'd128; gain = 16'd32768; end
            4: begin limit = 8'd40;  gain = 16'd1;    end
            default: begin
               limit = 8'($urandom_range(0, 255));
               gain  = 16'($urandom_range(0, 65535));
            end
         endcase
         case (p % 3)
            0: begin sender_idle_max = 6; receiver_idle_max = 6; end
            1: begin sender_idle_max = 0; receiver_idle_max = 0; end
            default: begin sender_idle_max = 0; receiver_idle_max = 6; end
         endcase
         hold_until_drained();
         repeat (4) @(posedge clock);
         apply_settings(limit, gain);
         run_phase(PHASE_ITEMS);
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d samples on all four channels under %0d register settings,",
               items_sent, settings_used);
      $display("with and without idle gaps; %0d results checked, %0d reports, %0d warnings.",
               tracker.checked, tracker.reports, tracker.warnings);
      if (tracker.errors == 0) begin
         $display("** sensor_channel_monitor: PASSED **");
      end else begin
         $display("** sensor_channel_monitor: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/scm_pkg.sv
hdl/sensor_channel_monitor.sv
tb/tb_top.sv
